FILE: design/ksm_pkg.sv
package ksm_pkg;

  // default sizes
  localparam int NumColumnsDefault = 16;
  localparam int QueueDepthDefault = 2;

  // field widths
  localparam int ColumnW = 4;
  localparam int NoteW   = 7;
  localparam int ChanW   = 4;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;
  localparam int MsgNum  = 3;
  localparam int MsgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRow1Base = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRow2Base = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVolStep  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgChannel  = 2'd3;

  // register reset values
  localparam logic [NoteW-1:0] Row1BaseReset = 7'h2B;
  localparam logic [NoteW-1:0] Row2BaseReset = 7'h3A;
  localparam logic [NoteW-1:0] VolStepReset  = 7'h0A;
  localparam logic [ChanW-1:0] ChannelReset  = 4'h0;

  // midi constants
  localparam logic [3:0]         StatusNoteOn  = 4'h9;
  localparam logic [3:0]         StatusControl = 4'hB;
  localparam logic [7:0]         CcModulation  = 8'h01;
  localparam logic [NoteW-1:0]   DataMax       = 7'h7F;
  localparam logic [ColumnW-1:0] NoteColMax    = 4'd14;
  localparam logic [ColumnW-1:0] ColVolDown    = 4'd0;
  localparam logic [ColumnW-1:0] ColVolUp      = 4'd1;
  localparam logic [ColumnW-1:0] ColVibrato    = 4'd2;

  // byte position inside a message
  localparam logic [1:0] FirstByte  = 2'd0;
  localparam logic [1:0] SecondByte = 2'd1;
  localparam logic [1:0] LastByte   = 2'd2;

  // message slots in output order
  localparam logic [MsgIdxW-1:0] SlotRow1 = 2'd0;
  localparam logic [MsgIdxW-1:0] SlotRow2 = 2'd1;
  localparam logic [MsgIdxW-1:0] SlotCtrl = 2'd2;

  typedef struct packed {
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } msg_t;

  // all messages caused by one column transaction
  typedef struct packed {
    msg_t [MsgNum-1:0] msg;
    logic [MsgNum-1:0] mask;
  } desc_t;

endpackage

FILE: design/ksm_fifo.sv
module ksm_fifo #(
  parameter int QUEUE_DEPTH = ksm_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ksm_pkg::desc_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ksm_pkg::desc_t  data_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  ksm_pkg::desc_t  mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/ksm_front.sv
module ksm_front #(
  parameter int NUM_COLUMNS = ksm_pkg::NumColumnsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ksm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ksm_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [ksm_pkg::ColumnW-1:0]   key_column_i,
  input  logic                          row1_pressed_i,
  input  logic                          row2_pressed_i,
  input  logic                          control_pressed_i,
  output logic                          push_o,
  output ksm_pkg::desc_t                desc_o
);

  localparam int IdxW = $clog2(NUM_COLUMNS);
  localparam int ColW = (IdxW > ksm_pkg::ColumnW) ? IdxW : ksm_pkg::ColumnW;

  logic [ksm_pkg::NoteW-1:0] row1_base_q, row2_base_q, vol_step_q;
  logic [ksm_pkg::ChanW-1:0] channel_q;

  logic [NUM_COLUMNS-1:0]    row1_prev_q, row1_prev_d;
  logic [NUM_COLUMNS-1:0]    row2_prev_q, row2_prev_d;
  logic [NUM_COLUMNS-1:0]    ctrl_prev_q, ctrl_prev_d;
  logic [ksm_pkg::NoteW-1:0] volume_q, volume_d;
  logic                      vibrato_q, vibrato_d;

  logic [ColW-1:0]           col_ext;
  logic [IdxW-1:0]           idx;
  logic                      col_ok, take, note_col;
  logic                      p1, p2, pc;
  logic                      edge1, edge2, ctrl_rise;
  logic [ksm_pkg::NoteW:0]   vol_sum;
  logic [ksm_pkg::NoteW-1:0] note1, note2;
  logic [7:0]                note_status, ctrl_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row1_base_q <= ksm_pkg::Row1BaseReset;
      row2_base_q <= ksm_pkg::Row2BaseReset;
      vol_step_q  <= ksm_pkg::VolStepReset;
      channel_q   <= ksm_pkg::ChannelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ksm_pkg::CfgRow1Base: row1_base_q <= cfg_wdata_i;
        ksm_pkg::CfgRow2Base: row2_base_q <= cfg_wdata_i;
        ksm_pkg::CfgVolStep:  vol_step_q  <= cfg_wdata_i;
        ksm_pkg::CfgChannel:  channel_q   <= cfg_wdata_i[ksm_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // column decode and previous levels
  assign col_ext  = ColW'(key_column_i);
  assign idx      = col_ext[IdxW-1:0];
  assign col_ok   = (32'(key_column_i) < NUM_COLUMNS);
  assign take     = accept_i && col_ok;
  assign note_col = (key_column_i <= ksm_pkg::NoteColMax);
  assign p1       = row1_prev_q[idx];
  assign p2       = row2_prev_q[idx];
  assign pc       = ctrl_prev_q[idx];

  // edge classification
  assign edge1     = row1_pressed_i ^ p1;
  assign edge2     = row2_pressed_i ^ p2;
  assign ctrl_rise = control_pressed_i && !pc;

  assign note1       = row1_base_q + ksm_pkg::NoteW'(key_column_i);
  assign note2       = row2_base_q + ksm_pkg::NoteW'(key_column_i);
  assign note_status = {ksm_pkg::StatusNoteOn, channel_q};
  assign ctrl_status = {ksm_pkg::StatusControl, channel_q};
  assign vol_sum     = {1'b0, volume_q} + {1'b0, vol_step_q};

  // state update
  always_comb begin
    row1_prev_d = row1_prev_q;
    row2_prev_d = row2_prev_q;
    ctrl_prev_d = ctrl_prev_q;
    volume_d    = volume_q;
    vibrato_d   = vibrato_q;
    if (take) begin
      row1_prev_d[idx] = row1_pressed_i;
      row2_prev_d[idx] = row2_pressed_i;
      ctrl_prev_d[idx] = control_pressed_i;
      if (ctrl_rise) begin
        if (key_column_i == ksm_pkg::ColVolDown) begin
          volume_d = (volume_q > vol_step_q) ? volume_q - vol_step_q : '0;
        end else if (key_column_i == ksm_pkg::ColVolUp) begin
          volume_d = vol_sum[ksm_pkg::NoteW] ? ksm_pkg::DataMax
                                             : vol_sum[ksm_pkg::NoteW-1:0];
        end else if (key_column_i == ksm_pkg::ColVibrato) begin
          vibrato_d = !vibrato_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row1_prev_q <= '0;
      row2_prev_q <= '0;
      ctrl_prev_q <= '0;
      volume_q    <= ksm_pkg::DataMax;
      vibrato_q   <= 1'b0;
    end else begin
      row1_prev_q <= row1_prev_d;
      row2_prev_q <= row2_prev_d;
      ctrl_prev_q <= ctrl_prev_d;
      volume_q    <= volume_d;
      vibrato_q   <= vibrato_d;
    end
  end

  // message descriptor, note on uses the volume before the control action
  always_comb begin
    desc_o = '0;
    desc_o.mask[ksm_pkg::SlotRow1] = edge1 && note_col;
    desc_o.mask[ksm_pkg::SlotRow2] = edge2 && note_col;
    desc_o.mask[ksm_pkg::SlotCtrl] = ctrl_rise && (key_column_i == ksm_pkg::ColVibrato);
    desc_o.msg[ksm_pkg::SlotRow1].b0 = note_status;
    desc_o.msg[ksm_pkg::SlotRow1].b1 = {1'b0, note1};
    desc_o.msg[ksm_pkg::SlotRow1].b2 = row1_pressed_i ? {1'b0, volume_q} : 8'h00;
    desc_o.msg[ksm_pkg::SlotRow2].b0 = note_status;
    desc_o.msg[ksm_pkg::SlotRow2].b1 = {1'b0, note2};
    desc_o.msg[ksm_pkg::SlotRow2].b2 = row2_pressed_i ? {1'b0, volume_q} : 8'h00;
    desc_o.msg[ksm_pkg::SlotCtrl].b0 = ctrl_status;
    desc_o.msg[ksm_pkg::SlotCtrl].b1 = ksm_pkg::CcModulation;
    desc_o.msg[ksm_pkg::SlotCtrl].b2 = vibrato_q ? 8'h00 : {1'b0, ksm_pkg::DataMax};
  end

  assign push_o = take && (desc_o.mask != '0);

endmodule

FILE: design/ksm_back.sv
module ksm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  ksm_pkg::desc_t  q_data_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // midi_byte[7:0]
  output logic            m_axis_tuser_o,  // message_end
  output logic            m_axis_tlast_o   // last
);

  ksm_pkg::desc_t              cur_q, cur_d;
  logic                        cur_valid_q, cur_valid_d;
  logic [1:0]                  byte_q, byte_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q;
  logic                        out_end_q, out_last_q;

  logic                        gen, msg_done, desc_done;
  logic [ksm_pkg::MsgIdxW-1:0] sel;
  logic [ksm_pkg::MsgNum-1:0]  sel_hot, rest;
  ksm_pkg::msg_t               msg;
  logic [7:0]                  byte_val;

  // pick the lowest pending message
  always_comb begin
    if (cur_q.mask[ksm_pkg::SlotRow1]) begin
      sel = ksm_pkg::SlotRow1;
    end else if (cur_q.mask[ksm_pkg::SlotRow2]) begin
      sel = ksm_pkg::SlotRow2;
    end else begin
      sel = ksm_pkg::SlotCtrl;
    end
  end

  assign sel_hot = ksm_pkg::MsgNum'(1) << sel;
  assign rest    = cur_q.mask & ~sel_hot;
  assign msg     = cur_q.msg[sel];

  always_comb begin
    case (byte_q)
      ksm_pkg::FirstByte:  byte_val = msg.b0;
      ksm_pkg::SecondByte: byte_val = msg.b1;
      default:             byte_val = msg.b2;
    endcase
  end

  assign gen       = cur_valid_q && (!out_valid_q || m_axis_tready_i);
  assign msg_done  = (byte_q == ksm_pkg::LastByte);
  assign desc_done = msg_done && (rest == '0);
  assign q_pop_o   = !cur_valid_q || (gen && desc_done);

  // byte sequencer
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    byte_d      = byte_q;
    if (gen) begin
      if (msg_done) begin
        byte_d     = ksm_pkg::FirstByte;
        cur_d.mask = rest;
      end else begin
        byte_d = byte_q + 1'b1;
      end
    end
    if (q_pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = q_valid_i;
      byte_d      = ksm_pkg::FirstByte;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (gen) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      byte_q      <= ksm_pkg::FirstByte;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (gen) begin
      out_byte_q <= byte_val;
      out_end_q  <= msg_done;
      out_last_q <= desc_done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_end_q;
  assign m_axis_tlast_o  = out_last_q;

  // the final byte of a column always closes a message
  a_last_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_end_q)
    else $error("tlast on a byte that does not end a message");

  // a loaded descriptor always has a message pending
  a_cur_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.mask != '0))
    else $error("active descriptor without pending message");

  // the byte counter stays within a three byte message
  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_q != 2'd3)
    else $error("byte position out of range");

  // a status byte follows every message end that is not the column end
  a_status_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen && msg_done && !desc_done |=> gen ? (byte_val[7] && byte_q == ksm_pkg::FirstByte)
                                          : 1'b1)
    else $error("message does not start with a status byte");

endmodule

FILE: design/key_scan_to_midi_encoder.sv
// key matrix scanner to midi byte stream
// path: with the back end idle, the first byte of a column's messages goes through the queue,
// the current descriptor register and the output register before it is valid
// throughput: one column transaction per cycle while the descriptor queue has room;
// output runs one byte per cycle while the receiver is ready, 3 bytes per message, up to 9
// bytes per column; columns that send no message are not queued
// reset: all keys released, volume 127, vibrato off, registers to defaults, queue empty
module key_scan_to_midi_encoder #(
  parameter int NUM_COLUMNS = ksm_pkg::NumColumnsDefault,
  parameter int QUEUE_DEPTH = ksm_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ksm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ksm_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // key_column[3:0], row1_pressed[4], row2_pressed[5], control_pressed[6], zero[7]
  input  logic [7:0]                  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // midi_byte[7:0]
  output logic [7:0]                  m_axis_tdata_o,
  // message_end[0]
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  logic           accept, push, full, q_valid, q_pop;
  ksm_pkg::desc_t push_desc, q_desc;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  // edge detection and message build
  ksm_front #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .key_column_i     (s_axis_tdata_i[3:0]),
    .row1_pressed_i   (s_axis_tdata_i[4]),
    .row2_pressed_i   (s_axis_tdata_i[5]),
    .control_pressed_i(s_axis_tdata_i[6]),
    .push_o           (push),
    .desc_o           (push_desc)
  );

  // descriptor queue
  ksm_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_desc),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_desc)
  );

  // byte serializer
  ksm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_desc),
    .q_pop_o        (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

FILE: tb/sv/ksm_midi_checker.sv
`timescale 1ns / 100ps

// watches both streams and the register port, predicts the midi bytes and compares
module ksm_midi_checker #(
  parameter int NUM_COLUMNS = ksm_pkg::NumColumnsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ksm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ksm_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [7:0]                  s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [7:0]                  m_tdata_i,
  input  logic                        m_tuser_i,
  input  logic                        m_tlast_i,
  input  logic                        end_check_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  import ksm_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       msg_end;
    logic       item_end;
  } midi_byte_t;

  // bytes still owed by the block, oldest first
  midi_byte_t midi_bytes_due[$];

  // shadow of the block's registers
  logic [NoteW-1:0] row1_base;
  logic [NoteW-1:0] row2_base;
  logic [NoteW-1:0] vol_step;
  logic [ChanW-1:0] channel;

  // shadow of the key levels and player controls
  logic             row1_held [NUM_COLUMNS];
  logic             row2_held [NUM_COLUMNS];
  logic             ctrl_held [NUM_COLUMNS];
  logic [NoteW-1:0] volume;
  logic             vibrato;
  logic             end_done;

  task automatic flag_mismatch(input string what);
    $display("midi check: byte %0d: %s", checked_o, what);
    fail_count_o++;
  endtask

  task automatic queue_message(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
    midi_bytes_due.push_back('{data: b0, msg_end: 1'b0, item_end: 1'b0});
    midi_bytes_due.push_back('{data: b1, msg_end: 1'b0, item_end: 1'b0});
    midi_bytes_due.push_back('{data: b2, msg_end: 1'b1, item_end: 1'b0});
  endtask

  // note on for a press, note on with velocity zero for a release
  task automatic note_edge(input logic [ColumnW-1:0] col, input logic was,
                           input logic now, input logic [NoteW-1:0] base);
    logic [NoteW-1:0] note;
    note = base + {3'b000, col};
    if (was != now && col <= NoteColMax)
      queue_message({StatusNoteOn, channel}, {1'b0, note},
                    now ? {1'b0, volume} : 8'h00);
  endtask

  // predicted effect of one scanned column
  task automatic scan_column(input logic [7:0] item);
    logic [ColumnW-1:0] col;
    logic               r1;
    logic               r2;
    logic               rc;
    logic [NoteW:0]     vol_sum;
    int                 first;
    col   = item[3:0];
    r1    = item[4];
    r2    = item[5];
    rc    = item[6];
    first = midi_bytes_due.size();
    if (int'(col) >= NUM_COLUMNS) return;

    note_edge(col, row1_held[col], r1, row1_base);
    row1_held[col] = r1;
    note_edge(col, row2_held[col], r2, row2_base);
    row2_held[col] = r2;

    // control row acts on press only, after the notes
    if (rc && !ctrl_held[col]) begin
      case (col)
        ColVolDown: begin
          volume = (volume > vol_step) ? volume - vol_step : '0;
        end
        ColVolUp: begin
          vol_sum = {1'b0, volume} + {1'b0, vol_step};
          volume  = (vol_sum > {1'b0, DataMax}) ? DataMax : vol_sum[NoteW-1:0];
        end
        ColVibrato: begin
          vibrato = ~vibrato;
          queue_message({StatusControl, channel}, CcModulation,
                        vibrato ? {1'b0, DataMax} : 8'h00);
        end
        default: ;
      endcase
    end
    ctrl_held[col] = rc;

    if (midi_bytes_due.size() > first)
      midi_bytes_due[midi_bytes_due.size()-1].item_end = 1'b1;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    midi_byte_t want;
    if (!rst_ni) begin
      midi_bytes_due.delete();
      row1_base    = Row1BaseReset;
      row2_base    = Row2BaseReset;
      vol_step     = VolStepReset;
      channel      = ChannelReset;
      volume       = DataMax;
      vibrato      = 1'b0;
      end_done     = 1'b0;
      fail_count_o = 0;
      checked_o    = 0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        row1_held[i] = 1'b0;
        row2_held[i] = 1'b0;
        ctrl_held[i] = 1'b0;
      end
    end else begin
      // output transaction against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        if (midi_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h", m_tdata_i));
        end else begin
          want = midi_bytes_due.pop_front();
          if (m_tdata_i !== want.data)
            flag_mismatch($sformatf("midi_byte %02h, expected %02h", m_tdata_i, want.data));
          if (m_tuser_i !== want.msg_end)
            flag_mismatch($sformatf("message_end %b, expected %b", m_tuser_i, want.msg_end));
          if (m_tlast_i !== want.item_end)
            flag_mismatch($sformatf("last %b, expected %b", m_tlast_i, want.item_end));
        end
        checked_o++;
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRow1Base: row1_base = cfg_wdata_i[NoteW-1:0];
          CfgRow2Base: row2_base = cfg_wdata_i[NoteW-1:0];
          CfgVolStep:  vol_step  = cfg_wdata_i[NoteW-1:0];
          CfgChannel:  channel   = cfg_wdata_i[ChanW-1:0];
          default: ;
        endcase
      end

      // input transaction
      if (s_tvalid_i && s_tready_i) scan_column(s_tdata_i);

      // leftovers once the run has drained
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (midi_bytes_due.size() != 0)
          flag_mismatch($sformatf("%0d expected bytes never arrived", midi_bytes_due.size()));
      end
    end
    pending_o = midi_bytes_due.size();
  end

endmodule

FILE: tb/sv/tb_key_scan_to_midi_encoder.sv
`timescale 1ns / 100ps

module tb_key_scan_to_midi_encoder;
  import ksm_pkg::*;

  localparam int CycleLimit = 500_000;
  localparam int SettlePad  = 8;
  localparam int PhaseItems = 62;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tuser;
  logic               m_tlast;
  logic               end_check;

  int  fail_count;
  int  pending;
  int  checked;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  settings    = 0;
  int  ready_hold  = 0;
  bit  quiet       = 1'b0;
  int  scan_col    = 0;
  logic [2:0] key_levels [16];

  key_scan_to_midi_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  ksm_midi_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .end_check_i  (end_check),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count, pending);
      $display("tb_key_scan_to_midi_encoder NOT OK");
      $finish;
    end
  end

  // receiver stalls: runs of ready and not ready, mostly short
  always @(negedge clk_i) begin
    if (quiet) begin
      m_tready   <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready   <= ($urandom_range(0, 99) < 70);
      ready_hold <= ($urandom_range(0, 99) < 6) ? $urandom_range(12, 30)
                                                : $urandom_range(0, 3);
    end
  end

  // all four registers in consecutive cycles
  task automatic write_settings(input logic [CfgW-1:0] r1, input logic [CfgW-1:0] r2,
                                input logic [CfgW-1:0] step, input logic [CfgW-1:0] chan);
    @(negedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CfgRow1Base; cfg_wdata <= r1;
    @(negedge clk_i);
    cfg_idx <= CfgRow2Base; cfg_wdata <= r2;
    @(negedge clk_i);
    cfg_idx <= CfgVolStep; cfg_wdata <= step;
    @(negedge clk_i);
    cfg_idx <= CfgChannel; cfg_wdata <= chan;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // one column transaction, levels are {control, row2, row1}
  task automatic send_column(input logic [3:0] col, input logic [2:0] lv);
    int gap;
    int r;
    r   = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, lv, col};
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  // stop sending and let every owed byte come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettlePad) @(posedge clk_i);
  endtask

  // mostly an in-order scan with slowly changing keys, some noise
  task automatic random_phase(input int n);
    logic [3:0] col;
    logic [2:0] lv;
    int         bit_idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        col      = 4'(scan_col);
        scan_col = (scan_col + 1) % 16;
        lv       = key_levels[col];
        if ($urandom_range(0, 99) < 40) begin
          bit_idx     = $urandom_range(0, 2);
          lv[bit_idx] = ~lv[bit_idx];
        end
      end else begin
        col = ($urandom_range(0, 99) < 50) ? 4'($urandom_range(0, 2))
                                           : 4'($urandom_range(0, 15));
        lv  = 3'($urandom_range(0, 7));
      end
      key_levels[col] = lv;
      send_column(col, lv);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    end_check = 1'b0;
    for (int i = 0; i < 16; i++) key_levels[i] = 3'b000;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, notes, volume and vibrato buttons
    send_column(4'd0, 3'b111);
    send_column(4'd0, 3'b000);
    send_column(4'd2, 3'b111);
    send_column(4'd2, 3'b000);
    send_column(4'd2, 3'b100);
    send_column(4'd2, 3'b000);
    send_column(4'd14, 3'b011);
    send_column(4'd14, 3'b000);
    send_column(4'd15, 3'b111);
    send_column(4'd15, 3'b000);
    send_column(4'd1, 3'b100);
    send_column(4'd1, 3'b000);
    send_column(4'd7, 3'b100);
    send_column(4'd7, 3'b000);
    send_column(4'd5, 3'b000);
    send_column(4'd9, 3'b010);
    send_column(4'd9, 3'b011);
    send_column(4'd9, 3'b000);
    wait_drained();

    // directed: top bases wrap, full step hits both volume limits, wide channel value
    write_settings(7'd127, 7'd127, 7'd127, 7'h7F);
    send_column(4'd14, 3'b011);
    send_column(4'd0, 3'b100);
    send_column(4'd0, 3'b000);
    send_column(4'd3, 3'b011);
    send_column(4'd3, 3'b000);
    send_column(4'd1, 3'b100);
    send_column(4'd1, 3'b000);
    key_levels[14] = 3'b011;
    random_phase(PhaseItems);
    wait_drained();

    // lowest bases and channel, unit step, no idling on either side
    quiet = 1'b1;
    write_settings(7'd0, 7'd0, 7'd1, 7'd0);
    random_phase(PhaseItems);
    wait_drained();
    quiet = 1'b0;

    // zero step keeps the volume, channel from the low bits only
    write_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 7'd0, 7'h5A);
    random_phase(PhaseItems);
    wait_drained();

    write_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(1, 127)), 7'($urandom_range(0, 15)));
    random_phase(PhaseItems);
    wait_drained();

    write_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'd64, 7'($urandom_range(0, 127)));
    random_phase(PhaseItems);
    wait_drained();

    // final leftover check in the checker
    @(negedge clk_i);
    end_check <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);

    $display("column transactions sent: %0d, midi bytes checked: %0d", items_sent, checked);
    $display("register settings used: %0d, mismatches: %0d", settings, fail_count);
    if (fail_count == 0) begin
      $display("tb_key_scan_to_midi_encoder OK");
    end else begin
      $display("tb_key_scan_to_midi_encoder NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ksm_pkg.sv
design/ksm_fifo.sv
design/ksm_front.sv
design/ksm_back.sv
design/key_scan_to_midi_encoder.sv
tb/sv/ksm_midi_checker.sv
tb/sv/tb_key_scan_to_midi_encoder.sv
